/* src/slm_pkg.sv */
// Shared constants for the sorted list merge block.
`default_nettype none
package slm_pkg;
    localparam int DEFAULT_LIST_DEPTH = 32;
    localparam int VALUE_W = 32;
    localparam int KIND_W = 2;
    localparam int USER_OUT_W = 2;

    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd2;

    // Bit positions inside the result tuser.
    localparam int USER_EMPTY_BIT = 0;
    localparam int USER_OVF_BIT   = 1;
endpackage
`default_nettype wire

/* src/slm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* src/sorted_list_merge.sv */
// Top level of the two-list ascending merge engine.
//
//  channel  | dir | tdata (low bit up)      | tuser (low bit up)         | tlast
//  s_*      | in  | value[31:0]             | kind[1:0]                  | -
//  m_*      | out | merged_value[31:0]      | empty_res, overflowed      | last
//
// An append goes straight into its list RAM, or is dropped (setting the drop
// flag) if that list is full. For each merge result ST_READ reads both list
// heads from the RAMs (registered read data), then ST_PICK compares them and
// loads the output register. Two empty lists give one result, marked empty
// and last. Reset clears the counts, pointers, drop flag, state and output
// valid, not the list contents. A stalled output holds the merge in place;
// s_tready is low from the merge transfer until its last result is loaded.
`default_nettype none
module sorted_list_merge #(
    parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [slm_pkg::VALUE_W-1:0]    s_tdata,   // value
    input  wire logic [slm_pkg::KIND_W-1:0]     s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [slm_pkg::VALUE_W-1:0]    m_tdata,   // merged_value
    output logic                                m_tlast,   // last
    output logic      [slm_pkg::USER_OUT_W-1:0] m_tuser    // empty_res, overflowed
);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0] ptr_a_reg, ptr_a_next, ptr_b_reg, ptr_b_next;
    logic          drop_reg, drop_next;

    logic                        out_valid_reg, out_valid_next;
    logic [slm_pkg::VALUE_W-1:0] out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_empty_reg, out_empty_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                        in_xfer;
    logic                        wr_a, wr_b, rd_en;
    logic [slm_pkg::VALUE_W-1:0] head_a, head_b;
    logic                        a_left, b_left, take_a, out_free;
    logic [TW-1:0]               total, emitted;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_a     = in_xfer && (s_tuser == slm_pkg::KIND_FIRST) && (cnt_a_reg != FULL);
    assign wr_b     = in_xfer && (s_tuser == slm_pkg::KIND_SECOND) && (cnt_b_reg != FULL);
    assign rd_en    = (state_reg == ST_READ);

    slm_ram #(
        .WIDTH(slm_pkg::VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_ram_a (
        .clk    (clk),
        .wr_en  (wr_a),
        .wr_addr(cnt_a_reg[AW-1:0]),
        .wr_data(s_tdata),
        .rd_en  (rd_en),
        .rd_addr(ptr_a_reg[AW-1:0]),
        .rd_data(head_a)
    );

    slm_ram #(
        .WIDTH(slm_pkg::VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_ram_b (
        .clk    (clk),
        .wr_en  (wr_b),
        .wr_addr(cnt_b_reg[AW-1:0]),
        .wr_data(s_tdata),
        .rd_en  (rd_en),
        .rd_addr(ptr_b_reg[AW-1:0]),
        .rd_data(head_b)
    );

    assign a_left   = (ptr_a_reg < cnt_a_reg);
    assign b_left   = (ptr_b_reg < cnt_b_reg);
    // On a tie the second list goes first.
    assign take_a   = a_left && (!b_left || ($signed(head_b) > $signed(head_a)));
    assign total    = TW'(cnt_a_reg) + TW'(cnt_b_reg);
    assign emitted  = TW'(ptr_a_reg) + TW'(ptr_b_reg) + TW'(1);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ptr_a_next     = ptr_a_reg;
        ptr_b_next     = ptr_b_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_tuser)
                        slm_pkg::KIND_FIRST:
                        begin
                            if (wr_a)
                            begin
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        slm_pkg::KIND_SECOND:
                        begin
                            if (wr_b)
                            begin
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        slm_pkg::KIND_MERGE:
                        begin
                            ptr_a_next = '0;
                            ptr_b_next = '0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = drop_reg;
                    if (total == '0)
                    begin
                        out_data_next  = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                    end
                    else
                    begin
                        out_data_next  = take_a ? head_a : head_b;
                        out_last_next  = (emitted == total);
                        out_empty_next = 1'b0;
                    end
                    if (take_a)
                    begin
                        ptr_a_next = ptr_a_reg + CW'(1);
                    end
                    else if (b_left)
                    begin
                        ptr_b_next = ptr_b_reg + CW'(1);
                    end
                    if ((total == '0) || (emitted == total))
                    begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    always_comb
    begin
        m_tuser = '0;
        m_tuser[slm_pkg::USER_EMPTY_BIT] = out_empty_reg;
        m_tuser[slm_pkg::USER_OVF_BIT]   = out_ovf_reg;
    end
endmodule
`default_nettype wire

/* src/slm_checker.sv */
// Port-level checks for the sorted list merge block, bound to the top level.
`default_nettype none
module slm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [slm_pkg::KIND_W-1:0]     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [slm_pkg::VALUE_W-1:0]    m_tdata,
    input wire logic                           m_tlast,
    input wire logic [slm_pkg::USER_OUT_W-1:0] m_tuser
);
    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
    else $error("result changed while stalled");

    // The empty-merge result is marked as the last result of its merge.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[slm_pkg::USER_EMPTY_BIT] |-> m_tlast)
    else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[slm_pkg::USER_EMPTY_BIT] |-> (m_tdata == '0))
    else $error("empty result carries a value");

    // A merge transfer makes the block busy in the next cycle.
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == slm_pkg::KIND_MERGE) |=> !s_tready)
    else $error("input accepted right after a merge command");
endmodule

bind sorted_list_merge slm_checker u_slm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
`default_nettype wire

/* sim/sorted_list_merge_tb.sv */
// Self-checking testbench for the sorted list merge block, with a merge predictor and scoreboard.

typedef struct packed {
    logic [slm_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        empty;
    logic                        ovf;
} merge_result_t;

class merge_scoreboard;
    logic signed [slm_pkg::VALUE_W-1:0] first_list [slm_pkg::DEFAULT_LIST_DEPTH];
    logic signed [slm_pkg::VALUE_W-1:0] second_list [slm_pkg::DEFAULT_LIST_DEPTH];
    int            first_len;
    int            second_len;
    bit            dropped;
    merge_result_t merge_q[$];
    int            errors;
    int            results_seen;
    int            appends_seen;
    int            merges_seen;
    int            drops_seen;

    function new();
        first_len    = 0;
        second_len   = 0;
        dropped      = 1'b0;
        errors       = 0;
        results_seen = 0;
        appends_seen = 0;
        merges_seen  = 0;
        drops_seen   = 0;
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Called on every accepted input transfer; a merge queues its whole output sequence.
    function void note_input(logic [slm_pkg::KIND_W-1:0] kind,
                             logic signed [slm_pkg::VALUE_W-1:0] value);
        merge_result_t r;
        int            i;
        int            j;
        int            total;
        case (kind)
            slm_pkg::KIND_FIRST:
            begin
                appends_seen++;
                if (first_len >= slm_pkg::DEFAULT_LIST_DEPTH)
                begin
                    dropped = 1'b1;
                    drops_seen++;
                end
                else
                begin
                    first_list[first_len] = value;
                    first_len++;
                end
            end
            slm_pkg::KIND_SECOND:
            begin
                appends_seen++;
                if (second_len >= slm_pkg::DEFAULT_LIST_DEPTH)
                begin
                    dropped = 1'b1;
                    drops_seen++;
                end
                else
                begin
                    second_list[second_len] = value;
                    second_len++;
                end
            end
            slm_pkg::KIND_MERGE:
            begin
                merges_seen++;
                total = first_len + second_len;
                if (total == 0)
                begin
                    r.value = '0;
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                    r.ovf   = dropped;
                    merge_q.push_back(r);
                end
                else
                begin
                    i = 0;
                    j = 0;
                    while (i < first_len || j < second_len)
                    begin
                        // The second list wins ties; the first head goes only when lower.
                        if (i < first_len && (j >= second_len || second_list[j] > first_list[i]))
                        begin
                            r.value = first_list[i];
                            i++;
                        end
                        else
                        begin
                            r.value = second_list[j];
                            j++;
                        end
                        r.last  = (i + j == total);
                        r.empty = 1'b0;
                        r.ovf   = dropped;
                        merge_q.push_back(r);
                    end
                end
                first_len  = 0;
                second_len = 0;
                dropped    = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    task check_result(logic [slm_pkg::VALUE_W-1:0] data, logic last,
                      logic [slm_pkg::USER_OUT_W-1:0] user);
        merge_result_t want;
        results_seen++;
        if (merge_q.size() == 0)
        begin
            report($sformatf("unexpected result %h last %b user %b", data, last, user));
            return;
        end
        want = merge_q.pop_front();
        // An empty-merge result carries a zero value.
        if (data !== want.value)
            report($sformatf("merged_value got %h, expected %h", data, want.value));
        if (last !== want.last)
            report($sformatf("last got %b, expected %b", last, want.last));
        if (user[slm_pkg::USER_EMPTY_BIT] !== want.empty)
            report($sformatf("empty_res got %b, expected %b",
                             user[slm_pkg::USER_EMPTY_BIT], want.empty));
        if (user[slm_pkg::USER_OVF_BIT] !== want.ovf)
            report($sformatf("overflowed got %b, expected %b",
                             user[slm_pkg::USER_OVF_BIT], want.ovf));
    endtask
endclass

module sorted_list_merge_tb;
    localparam logic [slm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 70;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [slm_pkg::VALUE_W-1:0]    s_tdata  = '0;
    logic [slm_pkg::KIND_W-1:0]     s_tuser  = slm_pkg::KIND_FIRST;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [slm_pkg::VALUE_W-1:0]    m_tdata;
    logic                           m_tlast;
    logic [slm_pkg::USER_OUT_W-1:0] m_tuser;

    merge_scoreboard sb = new();

    int burst_left      = 0;
    int list_items_sent = 0;
    bit hold_active     = 1'b0;
    bit hold_done       = 1'b0;

    sorted_list_merge #(
        .LIST_DEPTH(slm_pkg::DEFAULT_LIST_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("sorted_list_merge verification failed");
        $finish;
    end

    // Offers one item and returns right after its transfer; gaps come between bursts.
    task automatic send_item(input logic [slm_pkg::KIND_W-1:0] kind,
                             input logic signed [slm_pkg::VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(kind, value);
        burst_left--;
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom_range(0, 20) - 10;  // narrow range gives ties
            default: return $urandom;
        endcase
    endfunction

    task automatic make_run(ref int run[$], input int n, input bit sorted);
        int v;
        int pos;
        for (int k = 0; k < n; k++)
        begin
            v = pick_value();
            if (!sorted)
                run.push_back(v);
            else
            begin
                pos = 0;
                while (pos < run.size() && run[pos] <= v)
                    pos++;
                run.insert(pos, v);
            end
        end
    endtask

    // Loads both lists with interleaved appends, then issues the merge.
    task automatic send_lists(input int n_first, input int n_second, input bit sorted,
                              input bit noisy);
        int first_run[$];
        int second_run[$];
        make_run(first_run, n_first, sorted);
        make_run(second_run, n_second, sorted);
        while (first_run.size() > 0 || second_run.size() > 0)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_item(KIND_UNUSED, $urandom);
            if (first_run.size() > 0 && (second_run.size() == 0 || $urandom_range(0, 1) == 0))
                send_item(slm_pkg::KIND_FIRST, first_run.pop_front());
            else
                send_item(slm_pkg::KIND_SECOND, second_run.pop_front());
            list_items_sent++;
        end
        send_item(slm_pkg::KIND_MERGE, $urandom);
        list_items_sent++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both lists empty.
        send_item(slm_pkg::KIND_MERGE, 32'h0);
        // Extremes on both sides with ties at the minimum, zero and the maximum.
        send_item(slm_pkg::KIND_FIRST, 32'h8000_0000);
        send_item(slm_pkg::KIND_SECOND, 32'h8000_0000);
        send_item(slm_pkg::KIND_FIRST, 32'hffff_ffff);
        send_item(slm_pkg::KIND_SECOND, 32'h0);
        send_item(slm_pkg::KIND_FIRST, 32'h0);
        send_item(slm_pkg::KIND_SECOND, 32'h0);
        send_item(slm_pkg::KIND_FIRST, 32'h7fff_ffff);
        send_item(slm_pkg::KIND_SECOND, 32'h7fff_ffff);
        send_item(slm_pkg::KIND_MERGE, 32'hffff_ffff);
        // The unused kind must leave the lists alone.
        send_item(KIND_UNUSED, 32'hffff_ffff);
        send_item(KIND_UNUSED, 32'h0);
        // Only the first list, then only the second.
        send_item(slm_pkg::KIND_FIRST, 32'd5);
        send_item(slm_pkg::KIND_FIRST, 32'd7);
        send_item(slm_pkg::KIND_MERGE, 32'h0);
        send_item(slm_pkg::KIND_SECOND, -32'sd3);
        send_item(slm_pkg::KIND_MERGE, 32'h0);
        // Second list entirely above the first.
        send_item(slm_pkg::KIND_FIRST, 32'd1);
        send_item(slm_pkg::KIND_FIRST, 32'd2);
        send_item(slm_pkg::KIND_SECOND, 32'd100);
        send_item(slm_pkg::KIND_MERGE, 32'h0);

        // Overfill the first list so that appends get dropped.
        send_lists(slm_pkg::DEFAULT_LIST_DEPTH + 2, 3, 1'b1, 1'b0);
        while (list_items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:          send_lists(0, 0, 1'b1, 1'b0);
                1:          send_lists($urandom_range(0, 3),
                                       slm_pkg::DEFAULT_LIST_DEPTH + $urandom_range(1, 2),
                                       1'b1, 1'b1);
                2, 3, 4:    send_lists($urandom_range(0, 6), $urandom_range(0, 6), 1'b0, 1'b1);
                5, 6, 7:    send_lists($urandom_range(0, 8), $urandom_range(0, 8), 1'b1, 1'b1);
                default:    send_lists($urandom_range(0, 8), $urandom_range(0, 8), 1'b1, 1'b0);
            endcase
        end
        s_tvalid <= 1'b0;

        while (sb.merge_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d appends (%0d dropped on a full list) and %0d merges,",
                 sb.appends_seen, sb.drops_seen, sb.merges_seen);
        $display("%0d results checked; long output hold of %0d cycles done: %0d.",
                 sb.results_seen, LONG_HOLD, hold_done);
        if (sb.errors == 0)
            $display("sorted_list_merge verification clean");
        else
            $display("sorted_list_merge verification failed");
        $finish;
    end

    // Holds the output off once for a long stretch while the sender keeps offering items.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && sb.results_seen >= 8)
                break;
        end
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
    end

    // Result side: checks each transfer and drives tready in changing patterns.
    initial
    begin
        int mode;
        int mode_left;
        bit ready_next;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_active)
            begin
                ready_next = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = (mode_left % 3 != 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end
endmodule

/* files.f */
src/slm_pkg.sv
src/slm_ram.sv
src/sorted_list_merge.sv
src/slm_checker.sv
sim/sorted_list_merge_tb.sv
